### hdl/brq_pkg.sv
// Shared types and constants for the dynamic request batcher.
`default_nettype none
package brq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int SIZE_BITS_DEF   = 8;

  localparam int STAMP_W    = 32;
  localparam int MBS_W      = 8;
  localparam int DELAY_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int OP_W       = 2;
  localparam int ST_W       = 3;

  localparam logic [MBS_W-1:0]   MBS_RESET   = 8'd8;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_BATCH = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_READY = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MAX_BATCH = 1'd0,
    REG_MAX_DELAY = 1'd1
  } reg_addr_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_POP    = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic wrap;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### hdl/brq_req_if.sv
// Request and response channel interfaces of the batcher.
`default_nettype none
interface brq_req_if #(
  parameter int ID_BITS   = brq_pkg::ID_BITS_DEF,
  parameter int SIZE_BITS = brq_pkg::SIZE_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [brq_pkg::OP_W-1:0]  op;
  logic [ID_BITS-1:0]        req_id;
  logic [SIZE_BITS-1:0]      req_size;

  modport source (output valid, output op, output req_id, output req_size, input ready);
  modport sink   (input valid, input op, input req_id, input req_size, output ready);
endinterface

interface brq_res_if #(
  parameter int ID_BITS = brq_pkg::ID_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [brq_pkg::ST_W-1:0]  status;
  logic [ID_BITS-1:0]        batch_id;
  logic                      last;

  modport source (output valid, output status, output batch_id, output last, input ready);
  modport sink   (input valid, input status, input batch_id, input last, output ready);
endinterface
`default_nettype wire

### hdl/brq_cell.sv
// One queue cell: holds an entry and takes its neighbor's entry on a shift.
`default_nettype none
module brq_cell #(
  parameter int ID_BITS   = brq_pkg::ID_BITS_DEF,
  parameter int SIZE_BITS = brq_pkg::SIZE_BITS_DEF
) (
  input  wire                             clk,
  input  brq_pkg::cell_ctrl_t             ctrl,
  input  wire [ID_BITS-1:0]               wr_id,
  input  wire [SIZE_BITS-1:0]             wr_size,
  input  wire [brq_pkg::STAMP_W-1:0]      wr_stamp,
  input  wire [ID_BITS-1:0]               nbr_id,
  input  wire [SIZE_BITS-1:0]             nbr_size,
  input  wire [brq_pkg::STAMP_W-1:0]      nbr_stamp,
  input  wire [ID_BITS-1:0]               head_id,
  input  wire [SIZE_BITS-1:0]             head_size,
  input  wire [brq_pkg::STAMP_W-1:0]      head_stamp,
  output logic [ID_BITS-1:0]              ent_id,
  output logic [SIZE_BITS-1:0]            ent_size,
  output logic [brq_pkg::STAMP_W-1:0]     ent_stamp
);
  import brq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ent_id    <= wr_id;
      ent_size  <= wr_size;
      ent_stamp <= wr_stamp;
    end else if (ctrl.shift) begin
      // The cell at the tail of the occupied run closes the ring during a scan.
      if (ctrl.wrap) begin
        ent_id    <= head_id;
        ent_size  <= head_size;
        ent_stamp <= head_stamp;
      end else begin
        ent_id    <= nbr_id;
        ent_size  <= nbr_size;
        ent_stamp <= nbr_stamp;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/dynamic_request_batcher_top.sv
// Top level of the dynamic request batcher: cell chain and its controller.
//
// Channels: req (sink) carries op, req_id and req_size; res (source) carries
// status, batch_id and last. A beat moves when valid and ready are both high.
// The cfg port writes the batch size cap (index 0) or max_delay (index 1) on
// any edge with cfg_we high; write only while the block is idle.
// An enqueue answers with one beat that is valid in the cycle after
// acceptance. A tick gives no beat.
// A batch request rotates the occupied cells once through the head to add up
// sizes, decides in S_DECIDE, then shifts one released entry out per cycle
// whenever the result beat is free or being taken. One request item is worked
// on at a time, and req.ready is low until the previous answer has been taken.
// Reset clears the queue, the tick counter and the output register and puts
// the batch size cap to 8 and max_delay to 10. When res.ready is low the
// result beat holds and the chain waits.
`default_nettype none
module dynamic_request_batcher_top #(
  parameter int QUEUE_DEPTH = brq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = brq_pkg::ID_BITS_DEF,
  parameter int SIZE_BITS   = brq_pkg::SIZE_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  brq_req_if.sink                           req,
  brq_res_if.source                         res,
  input  wire                               cfg_we,
  input  wire [brq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire [brq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import brq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = ((SIZE_BITS > MBS_W) ? SIZE_BITS : MBS_W) + 1;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     rot_cnt;
  logic [CNT_W-1:0]     taken;
  logic [CNT_W-1:0]     pop_left;
  logic [SUM_W-1:0]     total;
  logic                 going;
  logic                 age_ok;
  logic [STAMP_W-1:0]   time_now;
  logic [MBS_W-1:0]     max_batch;
  logic [DELAY_W-1:0]   max_delay;

  logic                 out_valid;
  status_t              out_status;
  logic [ID_BITS-1:0]   out_id;
  logic                 out_last;

  logic [ID_BITS-1:0]   c_id    [QUEUE_DEPTH];
  logic [SIZE_BITS-1:0] c_size  [QUEUE_DEPTH];
  logic [STAMP_W-1:0]   c_stamp [QUEUE_DEPTH];

  logic                 accept;
  op_t                  in_op;
  logic                 too_large;
  logic                 q_full;
  logic                 enq_load;
  logic                 rot_en;
  logic                 pop_fire;
  logic [SUM_W-1:0]     sum_next;
  logic                 fits;
  logic                 sum_hit;
  logic [STAMP_W-1:0]   wait_ticks;

  assign req.ready    = (state == S_IDLE) && !out_valid;
  assign accept       = req.valid && req.ready;
  assign in_op        = op_t'(req.op);
  assign too_large    = SUM_W'(req.req_size) > SUM_W'(max_batch);
  assign q_full       = (count == CNT_W'(QUEUE_DEPTH));
  assign enq_load     = accept && (in_op == OP_ENQ) && !too_large && !q_full;
  assign rot_en       = (state == S_SCAN);
  assign pop_fire     = (state == S_POP) && (!out_valid || res.ready);
  assign sum_next     = total + SUM_W'(c_size[0]);
  assign fits         = (sum_next <= SUM_W'(max_batch));
  assign sum_hit      = (total == SUM_W'(max_batch));
  assign wait_ticks   = time_now - c_stamp[0];

  assign res.valid    = out_valid;
  assign res.status   = out_status;
  assign res.batch_id = out_id;
  assign res.last     = out_last;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % QUEUE_DEPTH;
    cell_ctrl_t ctrl;

    assign ctrl.load  = enq_load && (count == CNT_W'(i));
    assign ctrl.shift = rot_en || pop_fire;
    assign ctrl.wrap  = rot_en && (CNT_W'(i) == count - CNT_W'(1));

    brq_cell #(
      .ID_BITS   (ID_BITS),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_id      (req.req_id),
      .wr_size    (req.req_size),
      .wr_stamp   (time_now),
      .nbr_id     (c_id[NXT]),
      .nbr_size   (c_size[NXT]),
      .nbr_stamp  (c_stamp[NXT]),
      .head_id    (c_id[0]),
      .head_size  (c_size[0]),
      .head_stamp (c_stamp[0]),
      .ent_id     (c_id[i]),
      .ent_size   (c_size[i]),
      .ent_stamp  (c_stamp[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rot_cnt    <= '0;
      taken      <= '0;
      pop_left   <= '0;
      total      <= '0;
      going      <= 1'b0;
      age_ok     <= 1'b0;
      time_now   <= '0;
      max_batch  <= MBS_RESET;
      max_delay  <= DELAY_RESET;
      out_valid  <= 1'b0;
      out_status <= ST_OK;
      out_id     <= '0;
      out_last   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_addr_t'(cfg_addr))
          REG_MAX_BATCH: max_batch <= cfg_data[MBS_W-1:0];
          REG_MAX_DELAY: max_delay <= cfg_data[DELAY_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && res.ready && !pop_fire) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_op)
              OP_ENQ: begin
                out_valid <= 1'b1;
                out_id    <= '0;
                out_last  <= 1'b1;
                if (too_large) begin
                  out_status <= ST_TOO_LARGE;
                end else if (q_full) begin
                  out_status <= ST_FULL;
                end else begin
                  out_status <= ST_OK;
                  count      <= count + CNT_W'(1);
                end
              end
              OP_BATCH: begin
                if (count == '0) begin
                  out_valid  <= 1'b1;
                  out_status <= ST_EMPTY;
                  out_id     <= '0;
                  out_last   <= 1'b1;
                end else begin
                  age_ok    <= (wait_ticks >= STAMP_W'(max_delay));
                  total     <= '0;
                  taken     <= '0;
                  going     <= 1'b1;
                  rot_cnt   <= '0;
                  state     <= S_SCAN;
                end
              end
              OP_TICK: begin
                time_now <= time_now + STAMP_W'(1);
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // The head cell shows each queued entry in turn; after count
          // rotations the chain is back in its original order.
          if (going) begin
            if (fits) begin
              total <= sum_next;
              taken <= taken + CNT_W'(1);
            end else begin
              going <= 1'b0;
            end
          end
          rot_cnt <= rot_cnt + CNT_W'(1);
          if (rot_cnt == count - CNT_W'(1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if ((taken == '0) || !(sum_hit || age_ok)) begin
            out_valid  <= 1'b1;
            out_status <= ST_NOT_READY;
            out_id     <= '0;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end else begin
            pop_left <= taken;
            state    <= S_POP;
          end
        end
        S_POP: begin
          if (pop_fire) begin
            out_valid  <= 1'b1;
            out_status <= ST_OK;
            out_id     <= c_id[0];
            out_last   <= (pop_left == CNT_W'(1));
            count      <= count - CNT_W'(1);
            pop_left   <= pop_left - CNT_W'(1);
            if (pop_left == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### dv/brq_batch_checker.sv
// Scoreboard for the request batcher: mirrors its queue, predicts response beats and checks them.
module brq_batch_checker
  import brq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  brq_req_if                    req,
  brq_res_if                    res,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    beats_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    status_t                status;
    logic [ID_BITS_DEF-1:0] batch_id;
    logic                   last;
  } beat_t;

  // Mirror of the request queue and of the block's registers.
  logic [ID_BITS_DEF-1:0]       slot_id    [DEPTH];
  logic [SIZE_BITS_DEF-1:0]     slot_size  [DEPTH];
  logic [STAMP_W-1:0]           slot_stamp [DEPTH];
  logic [$clog2(DEPTH)-1:0]     head;
  logic [$clog2(DEPTH):0]       count;
  logic [STAMP_W-1:0]           ms_now;
  logic [MBS_W-1:0]             batch_cap;
  logic [DELAY_W-1:0]           delay_cap;

  beat_t awaited_beats[$];

  task automatic queue_beat(status_t st, logic [ID_BITS_DEF-1:0] id, logic lst);
    beat_t b;
    b.status   = st;
    b.batch_id = id;
    b.last     = lst;
    awaited_beats.insert(awaited_beats.size(), b);
  endtask

  task automatic predict_response(logic [OP_W-1:0] op, logic [ID_BITS_DEF-1:0] id,
                                  logic [SIZE_BITS_DEF-1:0] sz);
    int                       total;
    int                       taken;
    logic [$clog2(DEPTH)-1:0] slot;
    logic                     sum_hit;
    logic                     age_ok;
    case (op_t'(op))
      OP_ENQ: begin
        // The size check wins over the full check.
        if (sz > batch_cap) begin
          queue_beat(ST_TOO_LARGE, '0, 1'b1);
        end else if (count >= DEPTH) begin
          queue_beat(ST_FULL, '0, 1'b1);
        end else begin
          slot             = head + count[$clog2(DEPTH)-1:0];
          slot_id[slot]    = id;
          slot_size[slot]  = sz;
          slot_stamp[slot] = ms_now;
          count            = count + 1'b1;
          queue_beat(ST_OK, '0, 1'b1);
        end
      end
      OP_BATCH: begin
        if (count == 0) begin
          queue_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          total = 0;
          taken = 0;
          while (taken < count) begin
            slot = head + taken[$clog2(DEPTH)-1:0];
            if (total + int'(slot_size[slot]) > int'(batch_cap)) break;
            total += int'(slot_size[slot]);
            taken++;
          end
          sum_hit = (total == int'(batch_cap));
          age_ok  = (STAMP_W'(ms_now - slot_stamp[head]) >= STAMP_W'(delay_cap));
          if (taken == 0 || !(sum_hit || age_ok)) begin
            queue_beat(ST_NOT_READY, '0, 1'b1);
          end else begin
            for (int k = 0; k < taken; k++) begin
              slot = head + k[$clog2(DEPTH)-1:0];
              queue_beat(ST_OK, slot_id[slot], k == taken - 1);
            end
            head  = head + taken[$clog2(DEPTH)-1:0];
            count = count - taken[$clog2(DEPTH):0];
          end
        end
      end
      OP_TICK: ms_now = ms_now + 1'b1;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    beat_t got;
    beat_t want;
    if (rst) begin
      head       = '0;
      count      = '0;
      ms_now     = '0;
      batch_cap  = MBS_RESET;
      delay_cap  = DELAY_RESET;
      fail_count = 0;
      awaited_beats.delete();
    end else begin
      // Check the outgoing beat before predicting, so a beat with nothing
      // waiting is caught even if a new request is taken at the same edge.
      if (res.valid && res.ready) begin
        got.status   = status_t'(res.status);
        got.batch_id = res.batch_id;
        got.last     = res.last;
        if (awaited_beats.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat: status %0d id 0x%04h last %b",
                   $time, got.status, got.batch_id, got.last);
        end else begin
          want = awaited_beats.pop_front();
          if (got !== want) begin
            fail_count++;
            $display({"%0t: result mismatch: expected status %0d id 0x%04h last %b, ",
                      "got status %0d id 0x%04h last %b"},
                     $time, want.status, want.batch_id, want.last,
                     got.status, got.batch_id, got.last);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_addr == REG_MAX_BATCH) batch_cap = cfg_data[MBS_W-1:0];
        else delay_cap = cfg_data[DELAY_W-1:0];
      end
      if (req.valid && req.ready) predict_response(req.op, req.req_id, req.req_size);
    end
    beats_due = awaited_beats.size();
  end

endmodule

### dv/tb_dynamic_request_batcher_top.sv
// Testbench top for the request batcher: clock, reset, stimulus, back-pressure and verdict.
module tb_dynamic_request_batcher_top
  import brq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 60;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 40;
  localparam int PHASE_ITEMS = 13;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic [MBS_W-1:0]      size_cap;
  int                    fail_count;
  int                    beats_due;
  int                    beats_taken  = 0;
  int                    quiet_cycles = 0;

  brq_req_if req_ch ();
  brq_res_if res_ch ();

  dynamic_request_batcher_top DUT (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  brq_batch_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .beats_due  (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready) beats_taken <= beats_taken + 1;
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side: alternating ready and stall runs, plus one long hold-off
  // once traffic is under way so the request side backs up. The hold starts
  // only while the sender is offering an item.
  initial begin
    logic lvl;
    int   len;
    bit   held;
    lvl          = 1'b0;
    held         = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      if (!held && beats_taken >= HOLD_AFTER && req_ch.valid) begin
        held = 1'b1;
        lvl  = 1'b0;
        len  = HOLD_CYCLES;
      end else begin
        lvl = ~lvl;
        if (lvl) len = $urandom_range(1, 40);
        else len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 45) : $urandom_range(1, 3);
      end
      @(negedge clk);
      res_ch.ready <= lvl;
      repeat (len - 1) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high afterwards so back-to-back items need no extra edge.
  task automatic push_item(op_t op, logic [ID_BITS_DEF-1:0] id, logic [SIZE_BITS_DEF-1:0] sz);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.req_id   <= id;
    req_ch.req_size <= sz;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
  endtask

  // Ticks give no beat, so the block may still be busy after the last beat.
  task automatic set_limits(logic [MBS_W-1:0] mbs, logic [DELAY_W-1:0] dly);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_MAX_BATCH;
    cfg_data <= CFG_DATA_W'(mbs);
    @(negedge clk);
    cfg_addr <= REG_MAX_DELAY;
    cfg_data <= dly;
    @(negedge clk);
    cfg_we   <= 1'b0;
    size_cap = mbs;
  endtask

  // Mostly sizes that fit the current cap, so batches form; some oversize noise.
  task automatic random_phase(int n, bit pause_midway);
    int                       r;
    logic [SIZE_BITS_DEF-1:0] sz;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) wait_drained();
      r  = $urandom_range(0, 99);
      sz = ($urandom_range(0, 6) == 0) ? SIZE_BITS_DEF'($urandom_range(0, 255))
                                       : SIZE_BITS_DEF'($urandom_range(0, size_cap));
      if (r < 45) push_item(OP_ENQ, ID_BITS_DEF'($urandom), sz);
      else if (r < 72) push_item(OP_BATCH, ID_BITS_DEF'($urandom), sz);
      else if (r < 97) push_item(OP_TICK, ID_BITS_DEF'($urandom), sz);
      else push_item(OP_NONE, ID_BITS_DEF'($urandom), sz);
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_addr        = REG_MAX_BATCH;
    cfg_data        = '0;
    size_cap        = MBS_RESET;
    req_ch.valid    = 1'b0;
    req_ch.op       = OP_NONE;
    req_ch.req_id   = '0;
    req_ch.req_size = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty queue, oversize, zero size, exact fill, delay release.
    set_limits(8'd8, 16'd2);
    push_item(OP_BATCH, 16'h0000, 8'd0);
    push_item(OP_ENQ, 16'hFFFF, 8'd255);
    push_item(OP_ENQ, 16'h0000, 8'd0);
    push_item(OP_BATCH, 16'h0000, 8'd0);
    push_item(OP_ENQ, 16'h1234, 8'd8);
    push_item(OP_BATCH, 16'h0000, 8'd0);
    push_item(OP_NONE, 16'hFFFF, 8'd255);
    push_item(OP_ENQ, 16'h5A5A, 8'd3);
    push_item(OP_BATCH, 16'h0000, 8'd0);
    push_item(OP_TICK, 16'h0000, 8'd0);
    push_item(OP_TICK, 16'h0000, 8'd0);
    push_item(OP_BATCH, 16'h0000, 8'd0);

    // Fill the queue, then hit full and check that oversize still wins.
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
      push_item(OP_ENQ, ID_BITS_DEF'($urandom), (i == 0) ? 8'd5 : 8'd0);
    end
    push_item(OP_ENQ, 16'hA5A5, 8'd1);
    push_item(OP_ENQ, 16'h5A5A, 8'd200);

    // Lowered cap leaves the head entry too big to batch.
    set_limits(8'd4, 16'd2);
    push_item(OP_BATCH, 16'h0000, 8'd0);
    // Exact size match drains the whole queue even with the longest delay.
    set_limits(8'd5, 16'hFFFF);
    push_item(OP_BATCH, 16'h0000, 8'd0);
    // A zero cap: zero-size requests still form a batch.
    set_limits(8'd0, 16'hFFFF);
    push_item(OP_ENQ, ID_BITS_DEF'($urandom), 8'd0);
    push_item(OP_ENQ, ID_BITS_DEF'($urandom), 8'd0);
    push_item(OP_ENQ, ID_BITS_DEF'($urandom), 8'd1);
    push_item(OP_BATCH, 16'h0000, 8'd0);

    set_limits(MBS_RESET, DELAY_RESET);
    random_phase(PHASE_ITEMS, 1'b1);
    set_limits(8'd255, 16'hFFFF);
    random_phase(PHASE_ITEMS, 1'b0);
    set_limits(8'd255, 16'd0);
    random_phase(PHASE_ITEMS, 1'b0);
    set_limits(8'd1, 16'hFFFF);
    random_phase(PHASE_ITEMS, 1'b0);
    set_limits(MBS_W'($urandom_range(1, 255)), DELAY_W'($urandom_range(0, 15)));
    random_phase(PHASE_ITEMS, 1'b0);

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && beats_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
